### hw/rtl/fqvr_pkg.sv
// ----------------------------------------------------------------------------
// fqvr_pkg
// Shared types and codes for the FIFO queue with value removal.
// ----------------------------------------------------------------------------
package fqvr_pkg;

  // Request codes
  localparam logic [1:0] FN_PUSH   = 2'd0;
  localparam logic [1:0] FN_POP    = 2'd1;
  localparam logic [1:0] FN_REMOVE = 2'd2;

  // Status codes
  localparam logic [1:0] STS_DONE  = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;

  // Field widths
  localparam int unsigned FuncBits   = 2;
  localparam int unsigned ValueBits  = 32;
  localparam int unsigned StatusBits = 2;
  localparam int unsigned CountBits  = 5;
  localparam int unsigned CapBits    = 5;
  localparam int unsigned InBits     = 40;
  localparam int unsigned OutBits    = 40;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REMOVE,
    ST_HOLD
  } state_e;

  // Command broadcast to the cell row
  typedef struct packed {
    logic shift;  // every cell but the top one takes its upper neighbor's word; a load wins
    logic load;   // the addressed cell takes the broadcast word
  } cell_ctl_t;

endpackage

### hw/rtl/fqvr_cell.sv
// ----------------------------------------------------------------------------
// fqvr_cell
// One queue slot: holds a word, takes its neighbor's word on a shift or the
// broadcast word on a load.
// ----------------------------------------------------------------------------
module fqvr_cell #(
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 shift_i,
  input  logic                 load_i,
  input  logic [WORD_BITS-1:0] nbr_i,
  input  logic [WORD_BITS-1:0] bcast_i,
  output logic [WORD_BITS-1:0] data_o
);

  logic [WORD_BITS-1:0] data_q, data_d;

  always_comb begin
    data_d = data_q;
    if (load_i) begin
      data_d = bcast_i;
    end else if (shift_i) begin
      data_d = nbr_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### hw/rtl/fqvr_ctrl.sv
// ----------------------------------------------------------------------------
// fqvr_ctrl
// Request sequencer: fill count, capacity register, removal pass and the
// result register of the output stream.
// ----------------------------------------------------------------------------
module fqvr_ctrl #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [fqvr_pkg::FuncBits-1:0]     func_i,
  input  logic [fqvr_pkg::ValueBits-1:0]    value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [fqvr_pkg::OutBits-1:0]      out_data_o,
  input  logic                              cfg_valid_i,
  input  logic [fqvr_pkg::CapBits-1:0]      cfg_data_i,
  input  logic [WORD_BITS-1:0]              head_i,
  output fqvr_pkg::cell_ctl_t               ctl_o,
  output logic [$clog2(DEPTH)-1:0]          wr_pos_o,
  output logic [WORD_BITS-1:0]              wr_data_o
);
  import fqvr_pkg::*;

  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  state_e               state_q, state_d;
  logic [FW-1:0]        fill_q, fill_d;
  logic [FW-1:0]        rem_q, rem_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [CapBits-1:0]   cap_q;
  logic                 out_vld_q, out_vld_d;
  logic [OutBits-1:0]   out_q, out_d;
  logic [OutBits-1:0]   hold_q, hold_d;

  logic                 accept;
  logic                 full;
  logic [15:0]          eff_cap;
  logic                 out_free;
  logic                 res_vld;
  logic [ValueBits-1:0] res_popped;
  logic [StatusBits-1:0] res_status;
  logic [OutBits-1:0]   res_word;
  logic [WORD_BITS-1:0] in_word;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign in_word    = WORD_BITS'(value_i);
  assign eff_cap    = (16'(cap_q) > 16'(DEPTH)) ? 16'(DEPTH) : 16'(cap_q);
  assign full       = (16'(fill_q) >= eff_cap);
  assign out_free   = !out_vld_q || out_ready_i;

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    rem_d      = rem_q;
    word_d     = word_q;
    ctl_o      = '0;
    wr_pos_o   = '0;
    wr_data_o  = in_word;
    res_vld    = 1'b0;
    res_popped = '0;
    res_status = STS_DONE;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (func_i)
            FN_PUSH: begin
              res_vld = 1'b1;
              if (full) begin
                res_status = STS_FULL;
              end else begin
                ctl_o.load = 1'b1;
                wr_pos_o   = IW'(fill_q);
                fill_d     = fill_q + 1'b1;
              end
            end
            FN_POP: begin
              res_vld = 1'b1;
              if (fill_q == '0) begin
                res_status = STS_EMPTY;
              end else begin
                res_popped  = ValueBits'(head_i);
                ctl_o.shift = 1'b1;
                fill_d      = fill_q - 1'b1;
              end
            end
            FN_REMOVE: begin
              if (fill_q == '0) begin
                res_vld = 1'b1;
              end else begin
                word_d  = in_word;
                rem_d   = fill_q;
                state_d = ST_REMOVE;
              end
            end
            default: begin
              res_vld = 1'b1;
            end
          endcase
        end
      end
      ST_REMOVE: begin
        // Rotate the oldest word out; re-append it at the tail unless it matches.
        ctl_o.shift = 1'b1;
        wr_data_o   = head_i;
        if (head_i != word_q) begin
          ctl_o.load = 1'b1;
          wr_pos_o   = IW'(fill_q - 1'b1);
        end else begin
          fill_d = fill_q - 1'b1;
        end
        rem_d = rem_q - 1'b1;
        if (rem_q == FW'(1)) begin
          res_vld = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_HOLD: begin
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_word = {{(OutBits - ValueBits - StatusBits - CountBits){1'b0}},
                CountBits'(fill_d), res_status, res_popped};

    out_vld_d = out_vld_q;
    out_d     = out_q;
    hold_d    = hold_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (res_vld) begin
      if (out_free) begin
        out_vld_d = 1'b1;
        out_d     = res_word;
      end else begin
        // Park the result until the output register drains.
        hold_d  = res_word;
        state_d = ST_HOLD;
      end
    end else if (state_q == ST_HOLD && out_free) begin
      out_vld_d = 1'b1;
      out_d     = hold_q;
      state_d   = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      rem_q     <= '0;
      cap_q     <= CapBits'(16);
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      rem_q     <= rem_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
    out_q  <= out_d;
    hold_q <= hold_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/fifo_queue_with_value_removal.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_value_removal
// Push and pop: result goes to the output register, or to the hold register
// while the output stalls. Remove: one step of the cell row per held entry.
// Accepts one request at a time; a finished result may wait in the output.
// Reset clears fill, sequencer and output valid asynchronously and sets
// capacity to 16; cell contents stay undefined with no clearing pass.
// ----------------------------------------------------------------------------
module fifo_queue_with_value_removal #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned WORD_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [1:0] func, [33:2] value, [39:34] zero
  input  logic [fqvr_pkg::InBits-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [31:0] popped, [33:32] status, [38:34] count, [39] zero
  output logic [fqvr_pkg::OutBits-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fqvr_pkg::CapBits-1:0]  cfg_data_i
);
  import fqvr_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);

  cell_ctl_t            ctl;
  logic [IW-1:0]        wr_pos;
  logic [WORD_BITS-1:0] wr_data;
  logic [WORD_BITS-1:0] cell_data [DEPTH];

  assign cfg_ready_o = 1'b1;

  fqvr_ctrl #(
    .DEPTH     (DEPTH),
    .WORD_BITS (WORD_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .func_i      (s_axis_tdata[FuncBits-1:0]),
    .value_i     (s_axis_tdata[FuncBits+ValueBits-1:FuncBits]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .head_i      (cell_data[0]),
    .ctl_o       (ctl),
    .wr_pos_o    (wr_pos),
    .wr_data_o   (wr_data)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_BITS-1:0] nbr;
    if (i == DEPTH - 1) begin : g_last
      assign nbr = cell_data[i];
    end else begin : g_mid
      assign nbr = cell_data[i+1];
    end

    fqvr_cell #(
      .WORD_BITS (WORD_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (ctl.shift),
      .load_i  (ctl.load && (wr_pos == IW'(i))),
      .nbr_i   (nbr),
      .bcast_i (wr_data),
      .data_o  (cell_data[i])
    );
  end

endmodule

### hw/rtl/fqvr_checker.sv
// ----------------------------------------------------------------------------
// fqvr_checker
// Port-level checks on the result stream of the queue.
// ----------------------------------------------------------------------------
module fqvr_checker #(
  parameter int unsigned DEPTH = 16
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [fqvr_pkg::InBits-1:0]   s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [fqvr_pkg::OutBits-1:0]  m_axis_tdata,
  input logic                          cfg_valid_i,
  input logic                          cfg_ready_o,
  input logic [fqvr_pkg::CapBits-1:0]  cfg_data_i
);
  import fqvr_pkg::*;

  logic [StatusBits-1:0] status;
  logic [ValueBits-1:0]  popped;
  logic [CountBits-1:0]  count;

  assign popped = m_axis_tdata[ValueBits-1:0];
  assign status = m_axis_tdata[ValueBits+StatusBits-1:ValueBits];
  assign count  = m_axis_tdata[ValueBits+StatusBits+CountBits-1:ValueBits+StatusBits];

  // A refused request carries no word
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status != STS_DONE) |-> popped == '0)
    else $error("refused request returned a word");

  // An empty refusal reports a zero count
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == STS_EMPTY) |-> count == '0)
    else $error("empty refusal with nonzero count");

  // Count stays within the built depth (checked only for a depth under 32)
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (DEPTH < 32) |-> 32'(count) <= DEPTH)
    else $error("count above depth");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind fifo_queue_with_value_removal fqvr_checker #(.DEPTH(DEPTH)) u_fqvr_checker (.*);
